// ----- rtl/core/mclbc_pkg.sv -----
`timescale 1ns / 1ps

package mclbc_pkg;

   localparam int unsigned LFSR_W      = 8;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 8;
   localparam int unsigned KEY_STEPS   = 8;

   // clocking bit positions of the three registers
   localparam int unsigned CLK_POS_A   = 1;
   localparam int unsigned CLK_POS_B   = 2;
   localparam int unsigned CLK_POS_C   = 3;

   // register indexes of the configuration port
   localparam logic [CSR_ADDR_W-1:0] CSR_TAP_MASK        = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_OUT_AFTER_CLOCK = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MSB_NUMBERING   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SHIFT_TO_MSB    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_OUT_FROM_MSB    = 3'd4;

   typedef logic [LFSR_W-1:0] lfsr_type;

   typedef struct packed {
      lfsr_type tap_mask;
      logic     key_after_step;
      logic     msb_bit_numbering;
      logic     shift_toward_msb;
      logic     output_from_msb;
   } cfg_type;

   typedef struct packed {
      lfsr_type a;
      lfsr_type b;
      lfsr_type c;
   } lfsr_set_type;

   function automatic lfsr_type step_reg(input lfsr_type r, input cfg_type cfg);
      logic fb;
      fb = ^(r & cfg.tap_mask);
      if (cfg.shift_toward_msb) begin
         return {r[LFSR_W-2:0], fb};
      end
      return {fb, r[LFSR_W-1:1]};
   endfunction

   function automatic logic clock_bit(input lfsr_type r, input int unsigned pos,
                                      input cfg_type cfg);
      if (cfg.msb_bit_numbering) begin
         return r[LFSR_W-1-pos];
      end
      return r[pos];
   endfunction

   function automatic logic out_bit(input lfsr_type r, input cfg_type cfg);
      return cfg.output_from_msb ? r[LFSR_W-1] : r[0];
   endfunction

endpackage

// ----- rtl/core/mclbc_keygen.sv -----
`timescale 1ns / 1ps

module mclbc_keygen (
   input  mclbc_pkg::cfg_type            cfg,
   input  mclbc_pkg::lfsr_set_type       state_cur,
   output logic [mclbc_pkg::BYTE_W-1:0]  key_byte,
   output mclbc_pkg::lfsr_set_type       state_nxt
);

   // eight majority-clocked steps, key bits collected msb first
   always_comb begin
      mclbc_pkg::lfsr_set_type s;
      logic ca;
      logic cb;
      logic cc;
      logic maj;
      logic k;
      s        = state_cur;
      key_byte = '0;
      for (int i = 0; i < int'(mclbc_pkg::KEY_STEPS); i++) begin
         ca  = mclbc_pkg::clock_bit(s.a, mclbc_pkg::CLK_POS_A, cfg);
         cb  = mclbc_pkg::clock_bit(s.b, mclbc_pkg::CLK_POS_B, cfg);
         cc  = mclbc_pkg::clock_bit(s.c, mclbc_pkg::CLK_POS_C, cfg);
         maj = (ca & cb) | (ca & cc) | (cb & cc);
         k   = mclbc_pkg::out_bit(s.a, cfg) ^ mclbc_pkg::out_bit(s.b, cfg)
             ^ mclbc_pkg::out_bit(s.c, cfg);
         if (ca == maj) s.a = mclbc_pkg::step_reg(s.a, cfg);
         if (cb == maj) s.b = mclbc_pkg::step_reg(s.b, cfg);
         if (cc == maj) s.c = mclbc_pkg::step_reg(s.c, cfg);
         if (cfg.key_after_step) begin
            k = mclbc_pkg::out_bit(s.a, cfg) ^ mclbc_pkg::out_bit(s.b, cfg)
              ^ mclbc_pkg::out_bit(s.c, cfg);
         end
         key_byte[mclbc_pkg::BYTE_W-1-i] = k;
      end
      state_nxt = s;
   end

endmodule

// ----- rtl/core/majority_clocked_lfsr_byte_cipher_unit.sv -----
`timescale 1ns / 1ps

// Byte decryptor with three majority-clocked 8-bit LFSRs sharing one tap mask.
// Input channel req_: one cipher byte per item in req_tdata, req_tuser[0] set
// on the first byte of a message reloads all three registers with the tap mask
// before that byte. Result channel rsp_: the plain byte in rsp_tdata.
// Configuration: csr_we with csr_addr 0 tap mask, 1 output after clock,
// 2 msb bit numbering, 3 shift toward msb, 4 output from msb (data in csr_wdata
// low bits); other indexes are ignored. Write only while no item is in flight.
// Stages: an accepted item waits in the input register, then its result is
// written to the result register (two register stages: input, result).
// Throughput: one item per cycle unless rsp_ stalls; the eight keystream steps
// run as one combinational pass between the input and result registers.
// Reset clears the configuration, the registers (zero keystream until a
// message start) and both stages. When the receiver stalls, the result
// register holds, the input stage holds its item, and req_tready drops once
// both are full; nothing is lost or repeated.
module majority_clocked_lfsr_byte_cipher_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mclbc_pkg::BYTE_W-1:0]        req_tdata,   // [7:0] cipher_byte
   input  logic [0:0]                          req_tuser,   // [0] message_start
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mclbc_pkg::BYTE_W-1:0]        rsp_tdata,   // [7:0] plain_byte
   input  logic                                csr_we,
   input  logic [mclbc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [mclbc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   mclbc_pkg::cfg_type             cfg_ff, cfg_in;
   mclbc_pkg::lfsr_set_type        lfsr_ff, lfsr_in;
   mclbc_pkg::lfsr_set_type        state_cur, state_nxt;
   logic                           in_valid_ff, in_valid_in;
   logic [mclbc_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                           in_start_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [mclbc_pkg::BYTE_W-1:0]   rsp_data_ff;
   logic [mclbc_pkg::BYTE_W-1:0]   key_byte;
   logic                           req_fire;
   logic                           adv;

   assign adv        = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || adv;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            mclbc_pkg::CSR_TAP_MASK:        cfg_in.tap_mask = csr_wdata;
            mclbc_pkg::CSR_OUT_AFTER_CLOCK: cfg_in.key_after_step = csr_wdata[0];
            mclbc_pkg::CSR_MSB_NUMBERING:   cfg_in.msb_bit_numbering = csr_wdata[0];
            mclbc_pkg::CSR_SHIFT_TO_MSB:    cfg_in.shift_toward_msb = csr_wdata[0];
            mclbc_pkg::CSR_OUT_FROM_MSB:    cfg_in.output_from_msb = csr_wdata[0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   // message start reloads all three registers before this byte
   always_comb begin
      state_cur = lfsr_ff;
      if (in_start_ff) begin
         state_cur.a = cfg_ff.tap_mask;
         state_cur.b = cfg_ff.tap_mask;
         state_cur.c = cfg_ff.tap_mask;
      end
   end

   mclbc_keygen u_keygen (
      .cfg       (cfg_ff),
      .state_cur (state_cur),
      .key_byte  (key_byte),
      .state_nxt (state_nxt)
   );

   assign lfsr_in      = adv ? state_nxt : lfsr_ff;
   assign in_valid_in  = req_fire || (in_valid_ff && !adv);
   assign rsp_valid_in = adv || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         lfsr_ff      <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         lfsr_ff      <= lfsr_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser[0];
      end
      if (adv) begin
         rsp_data_ff <= in_byte_ff ^ key_byte;
      end
   end

   a_adv_gives_result: assert property (@(posedge clock) disable iff (reset)
      adv |=> rsp_valid_ff)
      else $error("item left the input stage without a result");

   a_zero_taps_pass: assert property (@(posedge clock) disable iff (reset)
      adv && in_start_ff && (cfg_ff.tap_mask == '0) |=> rsp_tdata == $past(in_byte_ff))
      else $error("zero tap mask at message start did not pass the byte through");

   a_lfsr_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(lfsr_ff))
      else $error("lfsr state changed without an item");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input taken while both stages are full and stalled");

endmodule
